@@ rtl/core/wsdf_pkg.sv @@
// Package for the WebSocket frame deframer.
// Holds the parse phase type and the header field constants; no dependencies.
package wsdf_pkg;

    typedef enum logic [2:0] {
        PH_HDR0    = 3'd0,
        PH_HDR1    = 3'd1,
        PH_LEN_MSB = 3'd2,
        PH_LEN_LSB = 3'd3,
        PH_KEY     = 3'd4,
        PH_PAYLOAD = 3'd5
    } t_phase;

    localparam logic [3:0] OPCODE_RESET  = 4'h2;   // binary frames
    localparam logic [6:0] LEN_CODE_EXT16 = 7'h7E;
    localparam logic [2:0] KEY_BYTES     = 3'd4;

endpackage

@@ rtl/core/websocket_frame_deframer.sv @@
// WebSocket frame deframer: splits a byte stream into frames and forwards the
// payload of final, unmasked frames with the selected opcode.
// Depends on wsdf_pkg.
//
//  channel | signals                                    | direction
//  --------+--------------------------------------------+----------
//  input   | i_in_valid, o_in_ready, i_in_byte           | in
//  output  | o_out_valid, i_out_ready, o_payload_byte,   | out
//          | o_frame_last                                |
//  config  | i_cfg_we, i_cfg_data                        | in
//
// One byte is accepted per cycle while o_in_ready is high; the header parser
// updates its state in the cycle of acceptance and a payload byte is registered.
// A skid register behind the output register keeps the input ready while the
// output stalls; the input drops ready only when both are full.
// Synchronous active-low reset returns the parser to the first header byte and
// the accepted opcode to binary. There is no clearing pass.
module websocket_frame_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_in_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_payload_byte,
    output logic       o_frame_last,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data
);

    wsdf_pkg::t_phase r_phase, n_phase;
    logic [15:0] r_frame_length, n_frame_length;
    logic [15:0] r_bytes_seen, n_bytes_seen;
    logic        r_drop_frame, n_drop_frame;
    logic        r_frame_masked, n_frame_masked;
    logic [2:0]  r_key_left, n_key_left;
    logic [3:0]  r_accept_opcode;

    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_last;
    logic        r_skid_valid;
    logic [7:0]  r_skid_byte;
    logic        r_skid_last;

    logic        in_fire;
    logic        out_fire;
    logic        res_valid;
    logic        res_last;
    logic [15:0] seen_inc;

    assign o_in_ready     = !r_skid_valid;
    assign in_fire        = i_in_valid && o_in_ready;
    assign out_fire       = r_out_valid && i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_frame_last   = r_out_last;
    assign seen_inc       = r_bytes_seen + 16'd1;

    always_comb begin
        n_phase        = r_phase;
        n_frame_length = r_frame_length;
        n_bytes_seen   = r_bytes_seen;
        n_drop_frame   = r_drop_frame;
        n_frame_masked = r_frame_masked;
        n_key_left     = r_key_left;
        res_valid      = 1'b0;
        res_last       = 1'b0;
        if (in_fire) begin
            unique case (r_phase)
                wsdf_pkg::PH_HDR1: begin
                    n_frame_masked = i_in_byte[7];
                    if (i_in_byte[6:0] == wsdf_pkg::LEN_CODE_EXT16) begin
                        n_phase = wsdf_pkg::PH_LEN_MSB;
                    end else begin
                        n_frame_length = {9'd0, i_in_byte[6:0]};
                        n_bytes_seen   = 16'd0;
                        if (i_in_byte[7]) begin
                            n_key_left = wsdf_pkg::KEY_BYTES;
                            n_phase    = wsdf_pkg::PH_KEY;
                        end else if (i_in_byte[6:0] == 7'd0) begin
                            n_phase = wsdf_pkg::PH_HDR0;
                        end else begin
                            n_phase = wsdf_pkg::PH_PAYLOAD;
                        end
                    end
                end
                wsdf_pkg::PH_LEN_MSB: begin
                    n_frame_length = {i_in_byte, 8'd0};
                    n_phase        = wsdf_pkg::PH_LEN_LSB;
                end
                wsdf_pkg::PH_LEN_LSB: begin
                    n_frame_length = {r_frame_length[15:8], i_in_byte};
                    n_bytes_seen   = 16'd0;
                    if (r_frame_masked) begin
                        n_key_left = wsdf_pkg::KEY_BYTES;
                        n_phase    = wsdf_pkg::PH_KEY;
                    end else if (n_frame_length == 16'd0) begin
                        n_phase = wsdf_pkg::PH_HDR0;
                    end else begin
                        n_phase = wsdf_pkg::PH_PAYLOAD;
                    end
                end
                wsdf_pkg::PH_KEY: begin
                    n_key_left = r_key_left - 3'd1;
                    if (n_key_left == 3'd0) begin
                        n_phase = (r_frame_length == 16'd0) ? wsdf_pkg::PH_HDR0
                                                            : wsdf_pkg::PH_PAYLOAD;
                    end
                end
                wsdf_pkg::PH_PAYLOAD: begin
                    n_bytes_seen = seen_inc;
                    res_valid    = !r_drop_frame && !r_frame_masked;
                    res_last     = (seen_inc == r_frame_length);
                    if (seen_inc == r_frame_length) begin
                        n_phase = wsdf_pkg::PH_HDR0;
                    end
                end
                default: begin
                    // First header byte; unused phase codes behave the same way.
                    n_drop_frame = !i_in_byte[7] || (i_in_byte[3:0] != r_accept_opcode);
                    n_phase      = wsdf_pkg::PH_HDR1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= wsdf_pkg::PH_HDR0;
            r_frame_length  <= 16'd0;
            r_bytes_seen    <= 16'd0;
            r_drop_frame    <= 1'b0;
            r_frame_masked  <= 1'b0;
            r_key_left      <= 3'd0;
            r_accept_opcode <= wsdf_pkg::OPCODE_RESET;
        end else begin
            r_phase        <= n_phase;
            r_frame_length <= n_frame_length;
            r_bytes_seen   <= n_bytes_seen;
            r_drop_frame   <= n_drop_frame;
            r_frame_masked <= n_frame_masked;
            r_key_left     <= n_key_left;
            if (i_cfg_we) begin
                r_accept_opcode <= i_cfg_data;
            end
        end
    end

    // Output register with a skid stage behind it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_fire) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_fire) begin
                r_out_byte <= r_skid_byte;
                r_out_last <= r_skid_last;
            end
        end else if (res_valid) begin
            if (!r_out_valid || out_fire) begin
                r_out_byte <= i_in_byte;
                r_out_last <= res_last;
            end else begin
                r_skid_byte <= i_in_byte;
                r_skid_last <= res_last;
            end
        end
    end

endmodule
